FILE: sv/ddpm_pkg.sv
// shared widths and the robot width reset value for the differential drive pwm mixer
package ddpm_pkg;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned OUT_W = 9;

  localparam logic [CFG_W-1:0] WHEEL_TRACK_RESET = CFG_W'(51);

endpackage

FILE: sv/ddpm_cfg_if.sv
// configuration write channel carrying the robot width
interface ddpm_cfg_if;
  import ddpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] wheel_track;

  modport source (output valid, output wheel_track, input ready);
  modport sink (input valid, input wheel_track, output ready);
endinterface

FILE: sv/ddpm_cmd_if.sv
// velocity command channel
interface ddpm_cmd_if;
  import ddpm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] lin_vel;
  logic signed [IN_W-1:0] yaw_rate;

  modport source (output valid, output lin_vel, output yaw_rate, input ready);
  modport sink (input valid, input lin_vel, input yaw_rate, output ready);
endinterface

FILE: sv/ddpm_pwm_if.sv
// wheel pwm duty result channel
interface ddpm_pwm_if;
  import ddpm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_pwm;
  logic signed [OUT_W-1:0] right_pwm;

  modport source (output valid, output left_pwm, output right_pwm, input ready);
  modport sink (input valid, input left_pwm, input right_pwm, output ready);
endinterface

FILE: sv/ddpm_scale.sv
// pipelined scaling of both wheel speeds by pwm_max over the divisor, with clamping
module ddpm_scale #(
  parameter int unsigned MAG_W   = 33,
  parameter int unsigned PWM_MAX = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [MAG_W-1:0] l_mag_i,
  input  logic [MAG_W-1:0] r_mag_i,
  input  logic             l_neg_i,
  input  logic             r_neg_i,
  input  logic [MAG_W-1:0] div_i,
  ddpm_pwm_if.source       pwm_o
);
  import ddpm_pkg::*;

  localparam int unsigned QW = $clog2(PWM_MAX + 1);
  localparam int unsigned NW = MAG_W + QW;
  localparam int unsigned XW = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;

  // multiply stage
  logic          vld_m_q;
  logic [NW-1:0] n_l_q, n_r_q;
  logic [MAG_W-1:0] dv_m_q;
  logic          neg_l_m_q, neg_r_m_q;
  logic          en_m;

  // overflow check and quotient bit stages
  logic             vld_s_q   [0:QW];
  logic [NW-1:0]    rem_l_q   [0:QW];
  logic [NW-1:0]    rem_r_q   [0:QW];
  logic [QW-1:0]    quo_l_q   [0:QW];
  logic [QW-1:0]    quo_r_q   [0:QW];
  logic [MAG_W-1:0] dv_q      [0:QW];
  logic             neg_l_q   [0:QW];
  logic             neg_r_q   [0:QW];
  logic             ovf_l_q   [0:QW];
  logic             ovf_r_q   [0:QW];
  logic             en_s      [0:QW];

  // output register
  logic                    out_vld_q;
  logic signed [OUT_W-1:0] left_q, right_q;
  logic                    en_out;

  always_comb begin
    en_out = !out_vld_q || pwm_o.ready;
    en_s[QW] = !vld_s_q[QW] || en_out;
    for (int k = QW - 1; k >= 0; k--) begin
      en_s[k] = !vld_s_q[k] || en_s[k+1];
    end
    en_m = !vld_m_q || en_s[0];
  end

  assign ready_o = en_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else if (en_m) begin
      vld_m_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      n_l_q     <= NW'(l_mag_i) * NW'(PWM_MAX);
      n_r_q     <= NW'(r_mag_i) * NW'(PWM_MAX);
      dv_m_q    <= div_i;
      neg_l_m_q <= l_neg_i;
      neg_r_m_q <= r_neg_i;
    end
  end

  // stage 0: quotient overflow against divisor shifted by the quotient width
  logic [NW-1:0] lim_s0;
  assign lim_s0 = NW'(dv_m_q) << QW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q[0] <= 1'b0;
    end else if (en_s[0]) begin
      vld_s_q[0] <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s[0]) begin
      rem_l_q[0] <= n_l_q;
      rem_r_q[0] <= n_r_q;
      quo_l_q[0] <= '0;
      quo_r_q[0] <= '0;
      dv_q[0]    <= dv_m_q;
      neg_l_q[0] <= neg_l_m_q;
      neg_r_q[0] <= neg_r_m_q;
      ovf_l_q[0] <= n_l_q >= lim_s0;
      ovf_r_q[0] <= n_r_q >= lim_s0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int unsigned SH = QW - k;
    logic [NW-1:0] trial;
    logic          ge_l, ge_r;
    logic [QW-1:0] quo_l_d, quo_r_d;

    always_comb begin
      trial = NW'(dv_q[k-1]) << SH;
      ge_l = rem_l_q[k-1] >= trial;
      ge_r = rem_r_q[k-1] >= trial;
      quo_l_d = quo_l_q[k-1];
      quo_r_d = quo_r_q[k-1];
      quo_l_d[SH] = ge_l;
      quo_r_d[SH] = ge_r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s_q[k] <= 1'b0;
      end else if (en_s[k]) begin
        vld_s_q[k] <= vld_s_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_s[k]) begin
        rem_l_q[k] <= ge_l ? rem_l_q[k-1] - trial : rem_l_q[k-1];
        rem_r_q[k] <= ge_r ? rem_r_q[k-1] - trial : rem_r_q[k-1];
        quo_l_q[k] <= quo_l_d;
        quo_r_q[k] <= quo_r_d;
        dv_q[k]    <= dv_q[k-1];
        neg_l_q[k] <= neg_l_q[k-1];
        neg_r_q[k] <= neg_r_q[k-1];
        ovf_l_q[k] <= ovf_l_q[k-1];
        ovf_r_q[k] <= ovf_r_q[k-1];
      end
    end
  end

  // clamp to pwm_max and apply the wheel sign
  logic [QW-1:0]        mag_l, mag_r;
  logic signed [XW-1:0] res_l, res_r;

  always_comb begin
    mag_l = (ovf_l_q[QW] || quo_l_q[QW] > QW'(PWM_MAX)) ? QW'(PWM_MAX) : quo_l_q[QW];
    mag_r = (ovf_r_q[QW] || quo_r_q[QW] > QW'(PWM_MAX)) ? QW'(PWM_MAX) : quo_r_q[QW];
    res_l = neg_l_q[QW] ? -$signed(XW'(mag_l)) : $signed(XW'(mag_l));
    res_r = neg_r_q[QW] ? -$signed(XW'(mag_r)) : $signed(XW'(mag_r));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_out) begin
      out_vld_q <= vld_s_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      left_q  <= res_l[OUT_W-1:0];
      right_q <= res_r[OUT_W-1:0];
    end
  end

  assign pwm_o.valid     = out_vld_q;
  assign pwm_o.left_pwm  = left_q;
  assign pwm_o.right_pwm = right_q;

endmodule

FILE: sv/differential_drive_pwm_mixer.sv
// top level of the differential drive velocity to pwm mixer
//
// cmd_i takes one request per cycle holding signed fixed point linear and
// angular velocities; pwm_o returns one request per command with the signed
// left and right wheel duties, in command order.
// cfg_i writes the robot width; it is always ready and should only be
// written while no command is in flight.
// the path from command to duty runs through kinematics stages a, b and c,
// the scaling by PWM_MAX, the overflow check, one quotient bit per stage
// of the restoring divider, and the output register.
// throughput is one command per cycle; each stage holds its request while
// the one after it is full, so a stall on pwm_o fills the pipeline and
// only then drops cmd_i.ready, and nothing is lost or repeated.
// reset empties the pipeline and loads the robot width with its default.
module differential_drive_pwm_mixer #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned PWM_MAX   = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddpm_cfg_if.sink   cfg_i,
  ddpm_cmd_if.sink   cmd_i,
  ddpm_pwm_if.source pwm_o
);
  import ddpm_pkg::*;

  localparam int unsigned AV_W = IN_W + 1;
  localparam int unsigned DU_W = CFG_W + IN_W;
  localparam int unsigned VU_W = AV_W + FRAC_BITS + 1;
  localparam int unsigned MW   = ((VU_W > DU_W) ? VU_W : DU_W) + 1;

  localparam logic signed [MW:0] ONE     = (MW + 1)'(1) << (2 * FRAC_BITS + 1);
  localparam logic signed [MW:0] NEG_ONE = -ONE;

  logic [CFG_W-1:0] wheel_track_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_track_q <= WHEEL_TRACK_RESET;
    end else if (cfg_i.valid) begin
      wheel_track_q <= cfg_i.wheel_track;
    end
  end

  logic en_a, en_b, en_c, scale_ready;
  logic vld_a_q, vld_b_q, vld_c_q;

  assign en_c = !vld_c_q || scale_ready;
  assign en_b = !vld_b_q || en_c;
  assign en_a = !vld_a_q || en_b;
  assign cmd_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (en_a) vld_a_q <= cmd_i.valid;
      if (en_b) vld_b_q <= vld_a_q;
      if (en_c) vld_c_q <= vld_b_q;
    end
  end

  // stage a: magnitudes and the turn term
  logic signed [AV_W-1:0] v_ext, w_ext, v_abs, w_abs;
  logic [AV_W-1:0] av_q;
  logic [DU_W-1:0] du_q;
  logic            v_neg_a_q, n_neg_a_q;

  always_comb begin
    v_ext = AV_W'(cmd_i.lin_vel);
    w_ext = AV_W'(cmd_i.yaw_rate);
    v_abs = v_ext[AV_W-1] ? -v_ext : v_ext;
    w_abs = w_ext[AV_W-1] ? -w_ext : w_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      av_q      <= v_abs;
      du_q      <= DU_W'(wheel_track_q) * DU_W'(w_abs[IN_W-1:0]);
      v_neg_a_q <= cmd_i.lin_vel[IN_W-1];
      n_neg_a_q <= !cmd_i.yaw_rate[IN_W-1] && (cmd_i.yaw_rate != '0);
    end
  end

  // stage b: wheel speeds
  logic [MW-1:0]        vu;
  logic signed [MW:0]   fast, slow, l_sel, r_sel;
  logic signed [MW:0]   l_q, r_q;

  always_comb begin
    vu    = MW'(av_q) << (FRAC_BITS + 1);
    fast  = $signed((MW + 1)'(vu)) + $signed((MW + 1)'(du_q));
    slow  = $signed((MW + 1)'(vu)) - $signed((MW + 1)'(du_q));
    l_sel = n_neg_a_q ? slow : fast;
    r_sel = n_neg_a_q ? fast : slow;
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      l_q <= v_neg_a_q ? -l_sel : l_sel;
      r_q <= v_neg_a_q ? -r_sel : r_sel;
    end
  end

  // stage c: divisor choice and sign magnitude split
  logic signed [MW:0] div_s, l_abs, r_abs;
  logic [MW-1:0]      div_q, l_mag_q, r_mag_q;
  logic               l_neg_q, r_neg_q;

  always_comb begin
    if (l_q > ONE || r_q > ONE) begin
      div_s = (l_q > r_q) ? l_q : r_q;
    end else if (l_q < NEG_ONE || r_q < NEG_ONE) begin
      div_s = (l_q < r_q) ? -l_q : -r_q;
    end else begin
      div_s = ONE;
    end
    l_abs = l_q[MW] ? -l_q : l_q;
    r_abs = r_q[MW] ? -r_q : r_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      div_q   <= div_s[MW-1:0];
      l_mag_q <= l_abs[MW-1:0];
      r_mag_q <= r_abs[MW-1:0];
      l_neg_q <= l_q[MW];
      r_neg_q <= r_q[MW];
    end
  end

  ddpm_scale #(
    .MAG_W   (MW),
    .PWM_MAX (PWM_MAX)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_c_q),
    .ready_o (scale_ready),
    .l_mag_i (l_mag_q),
    .r_mag_i (r_mag_q),
    .l_neg_i (l_neg_q),
    .r_neg_i (r_neg_q),
    .div_i   (div_q),
    .pwm_o   (pwm_o)
  );

endmodule

FILE: sim/differential_drive_pwm_mixer_tb.sv
// self-checking testbench for the differential drive pwm mixer
`timescale 1ns / 100ps

module differential_drive_pwm_mixer_tb;
  import ddpm_pkg::*;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PWM_MAX   = 255;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] right;
  } duty_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ddpm_cfg_if cfg_bus ();
  ddpm_cmd_if cmd_bus ();
  ddpm_pwm_if pwm_bus ();

  differential_drive_pwm_mixer #(
    .FRAC_BITS(FRAC_BITS),
    .PWM_MAX  (PWM_MAX)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .cmd_i (cmd_bus),
    .pwm_o (pwm_bus)
  );

  always #10 clk_i = ~clk_i;

  duty_pair_t       expected_duties[$];
  logic [CFG_W-1:0] track_width = WHEEL_TRACK_RESET;
  bit               quiet_tail = 1'b0;
  int               mismatch_count = 0;
  int               commands_sent = 0;
  int               duties_checked = 0;
  int               widths_written = 0;
  int               stall_left = 0;

  function automatic longint scale_duty(input longint speed, input longint divisor);
    longint q;
    q = (speed * longint'(PWM_MAX)) / divisor;
    if (q > longint'(PWM_MAX)) q = longint'(PWM_MAX);
    if (q < -longint'(PWM_MAX)) q = -longint'(PWM_MAX);
    return q;
  endfunction

  function automatic duty_pair_t mix_duties(input logic signed [IN_W-1:0] lin,
                                            input logic signed [IN_W-1:0] ang,
                                            input logic [CFG_W-1:0] width);
    longint     vel, yaw, vel_mag, yaw_mag, unit_speed, base, spread;
    longint     left_speed, right_speed, divisor;
    duty_pair_t duty;
    vel        = longint'(lin);
    yaw        = -longint'(ang);
    vel_mag    = (vel < 0) ? -vel : vel;
    yaw_mag    = (yaw < 0) ? -yaw : yaw;
    unit_speed = longint'(1) << (2 * FRAC_BITS + 1);
    base       = vel_mag << (FRAC_BITS + 1);
    spread     = longint'(width) * yaw_mag;
    if (yaw >= 0) begin
      left_speed  = base + spread;
      right_speed = base - spread;
    end else begin
      left_speed  = base - spread;
      right_speed = base + spread;
    end
    if (vel < 0) begin
      left_speed  = -left_speed;
      right_speed = -right_speed;
    end
    if (left_speed > unit_speed || right_speed > unit_speed) begin
      divisor = (left_speed > right_speed) ? left_speed : right_speed;
    end else if (left_speed < -unit_speed || right_speed < -unit_speed) begin
      divisor = (left_speed < right_speed) ? -left_speed : -right_speed;
    end else begin
      divisor = unit_speed;
    end
    duty.left  = OUT_W'(scale_duty(left_speed, divisor));
    duty.right = OUT_W'(scale_duty(right_speed, divisor));
    return duty;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // result checker and pwm ready driver
  always @(posedge clk_i) begin
    duty_pair_t want;
    if (!rst_ni) begin
      pwm_bus.ready <= 1'b0;
    end else begin
      if (pwm_bus.valid && pwm_bus.ready) begin
        if (expected_duties.size() == 0) begin
          report_mismatch($sformatf("unexpected duty request left %0d right %0d",
                                    pwm_bus.left_pwm, pwm_bus.right_pwm));
        end else begin
          want = expected_duties.pop_front();
          duties_checked++;
          if (pwm_bus.left_pwm !== want.left)
            report_mismatch($sformatf("left_pwm got %0d want %0d",
                                      pwm_bus.left_pwm, $signed(want.left)));
          if (pwm_bus.right_pwm !== want.right)
            report_mismatch($sformatf("right_pwm got %0d want %0d",
                                      pwm_bus.right_pwm, $signed(want.right)));
        end
      end
      if (quiet_tail) begin
        pwm_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pwm_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        pwm_bus.ready <= 1'b0;
      end else begin
        pwm_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(input logic signed [IN_W-1:0] lin,
                              input logic signed [IN_W-1:0] ang);
    duty_pair_t want;
    want = mix_duties(lin, ang, track_width);
    cmd_bus.valid    <= 1'b1;
    cmd_bus.lin_vel  <= lin;
    cmd_bus.yaw_rate <= ang;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_duties = {expected_duties, want};
    commands_sent++;
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] width);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.wheel_track <= width;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    track_width = width;
    widths_written++;
  endtask

  task automatic send_random(input int count);
    int lin, ang;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          lin = $urandom_range(0, 65535);
          ang = $urandom_range(0, 65535);
        end
        2, 3: begin
          lin = int'($urandom_range(0, 1200)) - 600;
          ang = int'($urandom_range(0, 1200)) - 600;
        end
        default: begin
          lin = int'($urandom_range(0, 600)) - 300;
          ang = int'($urandom_range(0, 80)) - 40;
        end
      endcase
      send_command(IN_W'(lin), IN_W'(ang));
    end
  endtask

  task automatic test_reset_width_corners();
    send_command(16'sd0, 16'sd0);
    send_command(16'sd32767, 16'sd0);
    send_command(-16'sd32768, 16'sd0);
    send_command(16'sd0, 16'sd32767);
    send_command(16'sd0, -16'sd32768);
    send_command(-16'sd32768, -16'sd32768);
    send_command(16'sd32767, 16'sd32767);
    send_command(-16'sd32768, 16'sd32767);
    send_command(16'sd256, 16'sd0);
    send_command(16'sd257, 16'sd0);
    send_command(-16'sd256, 16'sd0);
    send_command(-16'sd257, 16'sd0);
    send_command(16'sd128, 16'sd100);
    send_command(16'sd128, -16'sd100);
    send_command(-16'sd128, 16'sd100);
    send_command(-16'sd128, -16'sd100);
    send_command(16'sd0, 16'sd5000);
    send_command(16'sd0, -16'sd5000);
    send_command(-16'sd512, 16'sd10000);
    send_command(-16'sd512, -16'sd10000);
    send_command(16'sd512, 16'sd10000);
    send_command(-16'sd1, 16'sd1);
    wait_idle();
  endtask

  task automatic test_width_extremes();
    write_width(16'd0);
    send_command(16'sd100, 16'sd32767);
    send_random(110);
    wait_idle();
    write_width(16'hFFFF);
    send_command(16'sd100, 16'sd1);
    send_command(-16'sd32768, -16'sd32768);
    send_random(110);
    wait_idle();
  endtask

  task automatic test_random_widths();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase[0]) write_width(CFG_W'($urandom_range(1, 512)));
      else write_width(CFG_W'($urandom_range(0, 65535)));
      send_random(140);
      wait_idle();
    end
  endtask

  task automatic test_mid_pause();
    write_width(WHEEL_TRACK_RESET);
    send_random(60);
    // sender holds off until every duty has come back
    cmd_bus.valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk_i);
    send_random(60);
    wait_idle();
  endtask

  task automatic test_full_rate();
    quiet_tail = 1'b1;
    write_width(16'd256);
    send_random(200);
    wait_idle();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.wheel_track <= '0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.lin_vel     <= '0;
    cmd_bus.yaw_rate    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_width_corners();
    test_width_extremes();
    test_random_widths();
    test_mid_pause();
    test_full_rate();

    $display("covered %0d velocity commands and %0d duty checks over %0d width settings",
             commands_sent, duties_checked, widths_written + 1);
    $display("including zero, full-scale and reset widths, opposite overflow and stalls");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d duties outstanding", expected_duties.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
